@@ rtl/tgci_pkg.sv @@
package tgci_pkg;

    localparam int CELL_COUNT_DEF = 65536;
    localparam int EPOCH_W        = 8;
    localparam int G_W            = 43;
    localparam int NUM_W          = 24;
    localparam int DEN_W          = 16;

    localparam logic [15:0] CELL_SIZE_RST = 16'd100;
    localparam logic [16:0] COLUMNS_RST   = 17'd256;
    localparam logic [23:0] NEAR_RST      = 24'd5120;

    localparam logic [1:0] CFG_CELL_SIZE = 2'd0;
    localparam logic [1:0] CFG_COLUMNS   = 2'd1;
    localparam logic [1:0] CFG_NEAR      = 2'd2;

    typedef struct packed {
        logic        starts_trajectory;
        logic [30:0] point_time;
        logic [31:0] point_x;
        logic [31:0] point_y;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cell_index;
        logic [30:0] first_time;
        logic [30:0] latest_time;
        logic        out_of_range;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [30:0]        first_time;
    } t_entry;

endpackage

@@ rtl/tgci_div.sv @@
module tgci_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tgci_pkg::t_div_req             i_req,
    output logic                           o_done,
    output logic [tgci_pkg::NUM_W-1:0]     o_quot
);
    import tgci_pkg::*;

    logic             r_run;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    // Restoring division: the dividend shifts out of the top of r_q while
    // the quotient bits shift in at the bottom.
    assign rem_sh = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_rem <= '0;
                r_q   <= i_req.num;
                r_den <= i_req.den;
            end else if (r_run) begin
                r_rem <= fits ? (rem_sh - {1'b0, r_den}) : rem_sh;
                r_q   <= {r_q[NUM_W-2:0], fits};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(NUM_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ rtl/tgci_mul.sv @@
module tgci_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tgci_pkg::t_mul_req i_req,
    output logic               o_done,
    output logic [127:0]       o_prod
);
    import tgci_pkg::*;

    logic         r_run;
    logic         r_done;
    logic [2:0]   r_cnt;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [63:0]  r_p;
    logic         r_pv;
    logic [1:0]   r_sh;
    logic [127:0] r_acc;
    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [127:0] p_shifted;

    // One 32x32 partial product per cycle, added in the cycle after.
    assign a_part    = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign b_part    = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign p_shifted = {64'd0, r_p} << {r_sh, 5'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_pv   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_acc <= '0;
                r_pv  <= 1'b0;
                r_a   <= i_req.a;
                r_b   <= i_req.b;
            end else if (r_run) begin
                if (r_pv) begin
                    r_acc <= r_acc + p_shifted;
                end
                if (r_cnt != 3'd4) begin
                    r_p  <= 64'(a_part) * 64'(b_part);
                    r_sh <= 2'({1'b0, r_cnt[1]} + {1'b0, r_cnt[0]});
                    r_pv <= 1'b1;
                    r_cnt <= r_cnt + 3'd1;
                end else begin
                    r_pv   <= 1'b0;
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ rtl/tgci_store.sv @@
module tgci_store #(
    parameter int CELL_COUNT = tgci_pkg::CELL_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_we,
    input  logic [$clog2(CELL_COUNT)-1:0] i_addr,
    input  tgci_pkg::t_entry              i_wdata,
    output tgci_pkg::t_entry              o_rdata
);
    import tgci_pkg::*;

    t_entry mem [CELL_COUNT];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && !i_we) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/trajectory_grid_cell_indexer.sv @@
// Trajectory grid cell indexer. Each accepted point closes a segment from the previous
// point and the block delivers one to four cells that the segment covers, the last
// flagged last_of_run; a point that starts a trajectory, or the first point after
// reset, delivers nothing. One point at a time is worked on and the input is stalled
// meanwhile. The cost is set by one shared restoring divider (four divisions per
// segment) and one shared multiplier (2 products for the cell indices, 9 more when
// the end cells are diagonal neighbours), plus a store read per delivered cell. Visited
// cells are tracked by an epoch mark per cell in a single-port memory, so a new
// trajectory needs no clearing; after reset, and on every 255th trajectory start, a
// clearing pass over all CELL_COUNT cells runs with the input stalled.
module trajectory_grid_cell_indexer #(
    parameter int CELL_COUNT = tgci_pkg::CELL_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  tgci_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output tgci_pkg::t_out_item   o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [23:0]           i_cfg_data
);
    import tgci_pkg::*;

    localparam int ADDR_W = $clog2(CELL_COUNT);

    localparam logic [4:0] S_CLEAR   = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_DIV     = 5'd2;
    localparam logic [4:0] S_G1      = 5'd3;
    localparam logic [4:0] S_G2      = 5'd4;
    localparam logic [4:0] S_SORT    = 5'd5;
    localparam logic [4:0] S_BX      = 5'd6;
    localparam logic [4:0] S_BY      = 5'd7;
    localparam logic [4:0] S_T1      = 5'd8;
    localparam logic [4:0] S_T2      = 5'd9;
    localparam logic [4:0] S_M2      = 5'd10;
    localparam logic [4:0] S_NT      = 5'd11;
    localparam logic [4:0] S_DX2     = 5'd12;
    localparam logic [4:0] S_DY2     = 5'd13;
    localparam logic [4:0] S_RHS     = 5'd14;
    localparam logic [4:0] S_PICK    = 5'd15;
    localparam logic [4:0] S_EMIT_RD = 5'd16;
    localparam logic [4:0] S_EMIT_WR = 5'd17;
    localparam logic [4:0] S_FIN     = 5'd18;

    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

    logic [4:0]         r_state;
    logic [15:0]        r_cs;
    logic [16:0]        r_cols;
    logic [23:0]        r_nt;
    logic               r_have_prev;
    logic [31:0]        r_prev_x;
    logic [31:0]        r_prev_y;
    logic [30:0]        r_prev_time;
    t_in_item           r_cur;
    logic [1:0]         r_dk;
    logic [23:0]        r_c1;
    logic [23:0]        r_r1;
    logic [23:0]        r_c2;
    logic [23:0]        r_r2;
    logic [G_W-1:0]     r_g1;
    logic [G_W-1:0]     r_g2;
    logic [33:0]        r_bx;
    logic [33:0]        r_by;
    logic [56:0]        r_t1;
    logic [56:0]        r_t2;
    logic [127:0]       r_lhs;
    logic [47:0]        r_nt2;
    logic [63:0]        r_sum;
    logic [127:0]       r_rhs;
    logic [G_W-1:0]     r_list [4];
    logic [2:0]         r_nlist;
    logic [1:0]         r_k;
    logic               r_started;
    logic [EPOCH_W-1:0] r_epoch;
    logic [ADDR_W-1:0]  r_clr;
    logic               r_out_valid;
    t_out_item          r_out;

    t_mul_req           mul_req;
    logic               mul_done;
    logic [127:0]       mul_prod;
    t_div_req           div_req;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;

    logic               mem_en;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    t_entry             mem_wdata;
    t_entry             mem_rdata;

    logic [15:0]        cs_eff;
    logic [23:0]        side;
    logic               prev_left;
    logic [31:0]        xl;
    logic [31:0]        yl;
    logic [31:0]        xr;
    logic [31:0]        yr;
    logic [23:0]        cl;
    logic [23:0]        rl;
    logic [G_W-1:0]     gl;
    logic [G_W-1:0]     gr;
    logic               rising;
    logic [31:0]        dx;
    logic [31:0]        ady;
    logic [33:0]        a_mag;
    logic [33:0]        b_mag;
    logic [56:0]        mag;
    logic               col_adj;
    logic               row_adj;
    logic               is_mul_state;
    logic               mul_fin;
    logic               div_fin;
    logic [G_W-1:0]     cur_idx;
    logic               in_range;
    logic               visited;
    logic               out_free;
    logic               out_load;
    t_out_item          n_out;

    assign cs_eff    = (r_cs == 16'd0) ? 16'd1 : r_cs;
    assign side      = {cs_eff, 8'd0};
    assign prev_left = r_prev_x < r_cur.point_x;
    assign xl        = prev_left ? r_prev_x : r_cur.point_x;
    assign yl        = prev_left ? r_prev_y : r_cur.point_y;
    assign xr        = prev_left ? r_cur.point_x : r_prev_x;
    assign yr        = prev_left ? r_cur.point_y : r_prev_y;
    assign cl        = prev_left ? r_c1 : r_c2;
    assign rl        = prev_left ? r_r1 : r_r2;
    assign gl        = prev_left ? r_g1 : r_g2;
    assign gr        = prev_left ? r_g2 : r_g1;
    assign rising    = yl < yr;
    assign dx        = xr - xl;
    assign ady       = rising ? (yr - yl) : (yl - yr);
    // Both end offsets from the corner stay within one cell edge.
    assign a_mag     = rising ? (r_by - {2'd0, yl}) : ({2'd0, yl} - r_by);
    assign b_mag     = r_bx - {2'd0, xl};
    assign mag       = (r_t1 >= r_t2) ? (r_t1 - r_t2) : (r_t2 - r_t1);
    assign col_adj   = ({1'b0, r_c1} + 25'd1 == {1'b0, r_c2}) ||
                       ({1'b0, r_c2} + 25'd1 == {1'b0, r_c1});
    assign row_adj   = ({1'b0, r_r1} + 25'd1 == {1'b0, r_r2}) ||
                       ({1'b0, r_r2} + 25'd1 == {1'b0, r_r1});

    assign is_mul_state = (r_state == S_G1) || (r_state == S_G2) || (r_state == S_BX) ||
                          (r_state == S_BY) || (r_state == S_T1) || (r_state == S_T2) ||
                          (r_state == S_M2) || (r_state == S_NT) || (r_state == S_DX2) ||
                          (r_state == S_DY2) || (r_state == S_RHS);
    assign mul_fin = r_started && mul_done;
    assign div_fin = r_started && div_done;

    always_comb begin
        mul_req.start = is_mul_state && !r_started;
        mul_req.a     = '0;
        mul_req.b     = '0;
        case (r_state)
            S_G1: begin
                mul_req.a = 64'(r_r1);
                mul_req.b = 64'(r_cols);
            end
            S_G2: begin
                mul_req.a = 64'(r_r2);
                mul_req.b = 64'(r_cols);
            end
            S_BX: begin
                mul_req.a = 64'({1'b0, cl} + 25'd1);
                mul_req.b = 64'(side);
            end
            S_BY: begin
                mul_req.a = rising ? 64'({1'b0, rl} + 25'd1) : 64'(rl);
                mul_req.b = 64'(side);
            end
            S_T1: begin
                mul_req.a = 64'(a_mag);
                mul_req.b = 64'(dx);
            end
            S_T2: begin
                mul_req.a = 64'(b_mag);
                mul_req.b = 64'(ady);
            end
            S_M2: begin
                mul_req.a = 64'(mag);
                mul_req.b = 64'(mag);
            end
            S_NT: begin
                mul_req.a = 64'(r_nt);
                mul_req.b = 64'(r_nt);
            end
            S_DX2: begin
                mul_req.a = 64'(dx);
                mul_req.b = 64'(dx);
            end
            S_DY2: begin
                mul_req.a = 64'(ady);
                mul_req.b = 64'(ady);
            end
            S_RHS: begin
                mul_req.a = 64'(r_nt2);
                mul_req.b = r_sum;
            end
            default: begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    always_comb begin
        div_req.start = (r_state == S_DIV) && !r_started;
        div_req.den   = cs_eff;
        case (r_dk)
            2'd0:    div_req.num = r_prev_x[31:8];
            2'd1:    div_req.num = r_prev_y[31:8];
            2'd2:    div_req.num = r_cur.point_x[31:8];
            default: div_req.num = r_cur.point_y[31:8];
        endcase
    end

    tgci_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    tgci_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign cur_idx  = r_list[r_k];
    assign in_range = cur_idx < G_W'(CELL_COUNT);
    // A cell counts as visited only when its mark belongs to this trajectory.
    assign visited  = mem_rdata.epoch == r_epoch;
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == S_EMIT_WR) && out_free;

    always_comb begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = cur_idx[ADDR_W-1:0];
        mem_wdata.epoch      = r_epoch;
        mem_wdata.first_time = r_prev_time;
        if (r_state == S_CLEAR) begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = r_clr;
            mem_wdata.epoch      = '0;
            mem_wdata.first_time = '0;
        end else if (r_state == S_EMIT_RD) begin
            mem_en = 1'b1;
        end else if (out_load && in_range && !visited) begin
            mem_en = 1'b1;
            mem_we = 1'b1;
        end
    end

    tgci_store #(
        .CELL_COUNT (CELL_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_out.cell_index   = in_range ? cur_idx[15:0] : 16'd0;
        n_out.first_time   = (in_range && visited) ? mem_rdata.first_time : r_prev_time;
        n_out.latest_time  = r_cur.point_time;
        n_out.out_of_range = !in_range;
        n_out.last_of_run  = {1'b0, r_k} == (r_nlist - 3'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs   <= CELL_SIZE_RST;
            r_cols <= COLUMNS_RST;
            r_nt   <= NEAR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CELL_SIZE: r_cs   <= i_cfg_data[15:0];
                CFG_COLUMNS:   r_cols <= i_cfg_data[16:0];
                CFG_NEAR:      r_nt   <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_epoch     <= {{(EPOCH_W-1){1'b0}}, 1'b1};
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_time <= '0;
            r_started   <= 1'b0;
            r_dk        <= '0;
            r_k         <= '0;
            r_nlist     <= '0;
        end else begin
            if (is_mul_state || r_state == S_DIV) begin
                if (!r_started) begin
                    r_started <= 1'b1;
                end else if (mul_fin || div_fin) begin
                    r_started <= 1'b0;
                end
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(CELL_COUNT - 1)) begin
                        r_clr   <= '0;
                        r_epoch <= {{(EPOCH_W-1){1'b0}}, 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cur <= i_in_item;
                        if (i_in_item.starts_trajectory || !r_have_prev) begin
                            r_have_prev <= 1'b1;
                            r_prev_x    <= i_in_item.point_x;
                            r_prev_y    <= i_in_item.point_y;
                            r_prev_time <= i_in_item.point_time;
                            if (i_in_item.starts_trajectory) begin
                                if (r_epoch == EPOCH_MAX) begin
                                    r_state <= S_CLEAR;
                                end else begin
                                    r_epoch <= r_epoch + EPOCH_W'(1);
                                end
                            end
                        end else begin
                            r_dk    <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_fin) begin
                        case (r_dk)
                            2'd0:    r_c1 <= div_quot;
                            2'd1:    r_r1 <= div_quot;
                            2'd2:    r_c2 <= div_quot;
                            default: r_r2 <= div_quot;
                        endcase
                        r_dk <= r_dk + 2'd1;
                        if (r_dk == 2'd3) begin
                            r_state <= S_G1;
                        end
                    end
                end
                S_G1: begin
                    if (mul_fin) begin
                        r_g1    <= mul_prod[G_W-1:0] + G_W'(r_c1);
                        r_state <= S_G2;
                    end
                end
                S_G2: begin
                    if (mul_fin) begin
                        r_g2    <= mul_prod[G_W-1:0] + G_W'(r_c2);
                        r_state <= S_SORT;
                    end
                end
                S_SORT: begin
                    r_list[0] <= r_g1;
                    r_list[1] <= r_g2;
                    r_k       <= '0;
                    if (r_g1 == r_g2) begin
                        r_nlist <= 3'd1;
                        r_state <= S_EMIT_RD;
                    end else if (col_adj && row_adj) begin
                        r_state <= S_BX;
                    end else begin
                        r_nlist <= 3'd2;
                        r_state <= S_EMIT_RD;
                    end
                end
                S_BX: begin
                    if (mul_fin) begin
                        r_bx    <= mul_prod[33:0];
                        r_state <= S_BY;
                    end
                end
                S_BY: begin
                    if (mul_fin) begin
                        r_by    <= mul_prod[33:0];
                        r_state <= S_T1;
                    end
                end
                S_T1: begin
                    if (mul_fin) begin
                        r_t1    <= mul_prod[56:0];
                        r_state <= S_T2;
                    end
                end
                S_T2: begin
                    if (mul_fin) begin
                        r_t2    <= mul_prod[56:0];
                        r_state <= S_M2;
                    end
                end
                S_M2: begin
                    if (mul_fin) begin
                        r_lhs   <= mul_prod;
                        r_state <= S_NT;
                    end
                end
                S_NT: begin
                    if (mul_fin) begin
                        r_nt2   <= mul_prod[47:0];
                        r_state <= S_DX2;
                    end
                end
                S_DX2: begin
                    if (mul_fin) begin
                        r_sum   <= mul_prod[63:0];
                        r_state <= S_DY2;
                    end
                end
                S_DY2: begin
                    if (mul_fin) begin
                        // The squared length wraps at 64 bits.
                        r_sum   <= r_sum + mul_prod[63:0];
                        r_state <= S_RHS;
                    end
                end
                S_RHS: begin
                    if (mul_fin) begin
                        r_rhs   <= mul_prod;
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (r_lhs < r_rhs) begin
                        r_list[2] <= gl + G_W'(1);
                        r_list[3] <= gr - G_W'(1);
                        r_nlist   <= 3'd4;
                    end else begin
                        // The sign of the cross product picks the side cell.
                        if (rising ? (r_t1 > r_t2) : (r_t1 >= r_t2)) begin
                            r_list[2] <= gr - G_W'(1);
                        end else begin
                            r_list[2] <= gl + G_W'(1);
                        end
                        r_nlist <= 3'd3;
                    end
                    r_state <= S_EMIT_RD;
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_WR;
                end
                S_EMIT_WR: begin
                    if (out_free) begin
                        if ({1'b0, r_k} == (r_nlist - 3'd1)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                S_FIN: begin
                    r_prev_x    <= r_cur.point_x;
                    r_prev_y    <= r_cur.point_y;
                    r_prev_time <= r_cur.point_time;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !out_load)
        else $error("result loaded during clearing pass");

    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_RD) |-> (r_nlist != 3'd0 && r_nlist <= 3'd4))
        else $error("emitting with an empty result list");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("store written while idle");

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |-> (r_epoch != '0))
        else $error("current epoch equals the cleared mark");

    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_state != S_EMIT_WR))
        else $error("result loaded twice");

endmodule
